/* src/ring_window_min_max_tracker_assert.svh */
// Assertion macros shared by the tracker RTL.
`ifndef RING_WINDOW_MIN_MAX_TRACKER_ASSERT_SVH
`define RING_WINDOW_MIN_MAX_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define RWMM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RWMM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define RWMM_ASSERT(label, clk, rst, prop, msg)
`define RWMM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif
`endif

/* src/rwmm_pkg.sv */
package rwmm_pkg;

   localparam int RWMM_DEPTH = 32;
   localparam int DATA_W     = 32;
   localparam int POS_W      = 10;
   localparam int FUNC_W     = 2;

   // empty-ring markers for the held extremes
   localparam logic signed [DATA_W-1:0] SENT_MAX = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] SENT_MIN = 32'sh7FFF_FFFF;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic eval;
      logic scan;
      logic sweep;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_write;
      logic is_read;
      logic is_clear;
      logic bad_pos;
      logic rescan;
      logic scan_done;
      logic sweep_done;
   } stat_type;

endpackage

/* src/rwmm_if.sv */
interface rwmm_req_if import rwmm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] sample;

   modport source (output valid, output func, output position, output sample, input ready);
   modport sink (input valid, input func, input position, input sample, output ready);
endinterface

interface rwmm_rsp_if import rwmm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_value;
   logic signed [DATA_W-1:0] current_max;
   logic signed [DATA_W-1:0] current_min;
   logic                     range_error;

   modport source (output valid, output read_value, output current_max, output current_min,
                   output range_error, input ready);
   modport sink (input valid, input read_value, input current_max, input current_min,
                 input range_error, output ready);
endinterface

interface rwmm_csr_if import rwmm_pkg::*; ();
   logic valid;
   logic ready;
   logic auto_shift;

   modport source (output valid, output auto_shift, input ready);
   modport sink (input valid, input auto_shift, output ready);
endinterface

/* src/rwmm_ram.sv */
module rwmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rwmm_ctrl.sv */
`include "ring_window_min_max_tracker_assert.svh"

module rwmm_ctrl import rwmm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FETCH = 7'b0000010,
      S_EVAL  = 7'b0000100,
      S_SCAN  = 7'b0001000,
      S_SWEEP = 7'b0010000,
      S_INIT  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_ready & req_valid;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accept   = accept;
      cmd.fetch    = (state_ff == S_FETCH);
      cmd.eval     = (state_ff == S_EVAL);
      cmd.scan     = (state_ff == S_SCAN);
      cmd.sweep    = (state_ff == S_SWEEP) || (state_ff == S_INIT);
      cmd.load_rsp = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (stat.bad_pos) begin
                  state_in = S_EMIT;
               end else if (stat.is_write || stat.is_read) begin
                  state_in = S_FETCH;
               end else if (stat.is_clear) begin
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_FETCH: state_in = S_EVAL;
         S_EVAL: begin
            state_in = stat.rescan ? S_SCAN : S_EMIT;
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_EMIT;
         end
         S_SWEEP: begin
            if (stat.sweep_done) state_in = S_EMIT;
         end
         S_INIT: begin
            if (stat.sweep_done) state_in = S_IDLE;
         end
         S_EMIT: begin
            if (cmd.load_rsp) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold the result until taken; a new load replaces a taken one
   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RWMM_ASSERT(a_one_request_in_flight, clock, reset, accept |=> !req_ready, "second request taken before result")
   `RWMM_ASSERT(a_result_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT), "result raised outside emit")

endmodule

/* src/rwmm_dpath.sv */
`include "ring_window_min_max_tracker_assert.svh"

module rwmm_dpath import rwmm_pkg::*; #(
   parameter int DEPTH = RWMM_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     csr_write,
   input  logic                     csr_auto_shift,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic signed [DATA_W-1:0] rsp_current_max,
   output logic signed [DATA_W-1:0] rsp_current_min,
   output logic                     rsp_range_error
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_S  = DEPTH[AW:0];
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_LAST = CW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_END  = CW'(DEPTH);

   logic                     is_write, is_read, is_clear, pos_ok;
   logic [AW-1:0]            pos_idx, head_step, head_next, slot_next;
   logic [AW:0]              slot_sum;

   logic [AW-1:0]            head_ff, slot_ff;
   logic                     auto_shift_ff, op_write_ff;
   logic signed [DATA_W-1:0] sample_ff, max_ff, min_ff;
   logic signed [DATA_W-1:0] pend_read_ff;
   logic                     pend_err_ff;
   logic                     rescan_max_ff, rescan_min_ff;
   logic signed [DATA_W-1:0] acc_max_ff, acc_min_ff;
   logic [CW-1:0]            cnt_ff;
   logic signed [DATA_W-1:0] rsp_read_ff, rsp_max_ff, rsp_min_ff;
   logic                     rsp_err_ff;

   logic                     ram_wr_en, ram_rd_en;
   logic [AW-1:0]            ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0]        ram_wr_data, ram_rd_raw;
   logic signed [DATA_W-1:0] ram_rd;
   logic                     eq_max, eq_min, scan_first;
   logic signed [DATA_W-1:0] fold_max, fold_min;

   // request decode
   assign is_write = (req_func == FUNC_WRITE);
   assign is_read  = (req_func == FUNC_READ);
   assign is_clear = (req_func == FUNC_CLEAR);
   assign pos_ok   = (32'(req_position) < DEPTH);
   assign pos_idx  = req_position[AW-1:0];

   // head steps back with wrap on an in-range write with auto-shift set, then slot = head + position mod DEPTH
   assign head_step = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign head_next = (is_write && pos_ok && auto_shift_ff) ? head_step : head_ff;
   assign slot_sum  = {1'b0, head_next} + {1'b0, pos_idx};
   assign slot_next = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : slot_sum[AW-1:0];

   assign ram_rd = ram_rd_raw;
   assign eq_max = (ram_rd == max_ff);
   assign eq_min = (ram_rd == min_ff);

   assign scan_first = (cnt_ff == CW'(1));
   assign fold_max   = (scan_first || ram_rd > acc_max_ff) ? ram_rd : acc_max_ff;
   assign fold_min   = (scan_first || ram_rd < acc_min_ff) ? ram_rd : acc_min_ff;

   always_comb begin
      stat.is_write   = is_write;
      stat.is_read    = is_read;
      stat.is_clear   = is_clear;
      stat.bad_pos    = (is_write || is_read) && !pos_ok;
      stat.rescan     = cmd.eval && op_write_ff && (eq_max || eq_min);
      stat.scan_done  = cmd.scan && (cnt_ff == CNT_END);
      stat.sweep_done = cmd.sweep && (cnt_ff == CNT_LAST);
   end

   // memory port steering
   assign ram_wr_en   = cmd.sweep || (cmd.eval && op_write_ff);
   assign ram_wr_addr = cmd.sweep ? cnt_ff[AW-1:0] : slot_ff;
   assign ram_wr_data = cmd.sweep ? '0 : sample_ff;
   assign ram_rd_en   = cmd.fetch || (cmd.scan && (cnt_ff < CNT_END));
   assign ram_rd_addr = cmd.scan ? cnt_ff[AW-1:0] : slot_ff;

   rwmm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         auto_shift_ff <= 1'b0;
         op_write_ff   <= 1'b0;
         max_ff        <= SENT_MAX;
         min_ff        <= SENT_MIN;
         cnt_ff        <= '0;
      end else begin
         if (csr_write) auto_shift_ff <= csr_auto_shift;
         cnt_ff <= (cmd.scan || cmd.sweep) ? cnt_ff + 1'b1 : '0;
         if (cmd.accept) begin
            head_ff     <= head_next;
            op_write_ff <= is_write && pos_ok;
            if (is_clear) begin
               max_ff <= SENT_MAX;
               min_ff <= SENT_MIN;
            end
         end
         if (cmd.eval && op_write_ff) begin
            if (sample_ff > max_ff) max_ff <= sample_ff;
            if (sample_ff < min_ff) min_ff <= sample_ff;
         end
         // the scan result replaces an evicted extreme
         if (stat.scan_done) begin
            if (rescan_max_ff) max_ff <= fold_max;
            if (rescan_min_ff) min_ff <= fold_min;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         slot_ff      <= slot_next;
         sample_ff    <= req_sample;
         pend_read_ff <= '0;
         pend_err_ff  <= stat.bad_pos;
      end
      if (cmd.eval) begin
         if (op_write_ff) begin
            rescan_max_ff <= eq_max;
            rescan_min_ff <= eq_min;
         end else begin
            pend_read_ff <= ram_rd;
         end
      end
      if (cmd.scan && cnt_ff != '0) begin
         acc_max_ff <= fold_max;
         acc_min_ff <= fold_min;
      end
      if (cmd.load_rsp) begin
         rsp_read_ff <= pend_read_ff;
         rsp_max_ff  <= max_ff;
         rsp_min_ff  <= min_ff;
         rsp_err_ff  <= pend_err_ff;
      end
   end

   assign rsp_read_value  = rsp_read_ff;
   assign rsp_current_max = rsp_max_ff;
   assign rsp_current_min = rsp_min_ff;
   assign rsp_range_error = rsp_err_ff;

   `RWMM_ASSERT(a_extremes_ordered, clock, reset, (max_ff >= min_ff) || (max_ff == SENT_MAX && min_ff == SENT_MIN), "held maximum below held minimum")
   `RWMM_ASSERT_IMPL(a_head_steps_back, clock, reset, head_ff != $past(head_ff), (head_ff == $past(head_ff) - 1'b1) || ($past(head_ff) == '0 && head_ff == LAST_IDX), "head moved by more than one slot")
   `RWMM_ASSERT_IMPL(a_scan_has_cause, clock, reset, stat.scan_done, rescan_max_ff || rescan_min_ff, "scan finished with no evicted extreme")

endmodule

/* src/ring_window_min_max_tracker.sv */
// Range errors and unused funcs skip the RAM; reads and writes fetch and evaluate a slot,
//   a write that evicts a held extreme also rescans the ring, and a clear sweeps it.
// Throughput: one request in flight; the next can be taken once its result is registered,
//   also while that result waits. The extreme rescan reads all DEPTH slots through the one RAM read port.
// Reset: synchronous; a sweep zeroes the ring, no request is taken meanwhile,
//   configuration writes are taken at any time outside reset.
module ring_window_min_max_tracker import rwmm_pkg::*; #(
   parameter int DEPTH = RWMM_DEPTH
) (
   input logic        clock,
   input logic        reset,
   rwmm_req_if.sink   req_bus,
   rwmm_rsp_if.source rsp_bus,
   rwmm_csr_if.sink   csr_bus
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_bus.ready = 1'b1;

   rwmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rwmm_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_bus.func),
      .req_position    (req_bus.position),
      .req_sample      (req_bus.sample),
      .csr_write       (csr_bus.valid),
      .csr_auto_shift  (csr_bus.auto_shift),
      .rsp_read_value  (rsp_bus.read_value),
      .rsp_current_max (rsp_bus.current_max),
      .rsp_current_min (rsp_bus.current_min),
      .rsp_range_error (rsp_bus.range_error)
   );

endmodule
